// File: rtl/duplicate_segment_id_filter_core_macros.svh
// Assertion macros for the duplicate segment identifier filter.
// Taken in by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef DUPLICATE_SEGMENT_ID_FILTER_CORE_MACROS_SVH
`define DUPLICATE_SEGMENT_ID_FILTER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DSIF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSIF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dsif_pkg.sv
// Shared types and constants for the duplicate segment identifier filter.
// No dependencies; used by dsif_cell and duplicate_segment_id_filter_core.
`timescale 1ns / 1ps
`default_nettype none

package dsif_pkg;

   localparam int ID_WIDTH           = 32;
   localparam int RSP_DATA_WIDTH     = 8;
   localparam int WINDOW_DEPTH_DEF   = 16;

   typedef logic [ID_WIDTH-1:0] seg_ident_type;

   // Broadcast from the controller to every cell of the window.
   typedef struct packed {
      logic          shift;
      seg_ident_type query;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_DECIDE
   } state_type;

endpackage

`default_nettype wire

// File: rtl/dsif_cell.sv
// One window cell: holds a stored identifier and its valid flag, registers its match.
// Depends on dsif_pkg; instantiated in a chain by duplicate_segment_id_filter_core.
`timescale 1ns / 1ps
`default_nettype none

module dsif_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  dsif_pkg::cell_ctrl_type ctrl,
   input  dsif_pkg::seg_ident_type prev_id,
   input  wire                     prev_valid,
   output dsif_pkg::seg_ident_type id_out,
   output logic                    valid_out,
   output logic                    match_out
);

   dsif_pkg::seg_ident_type id_ff;
   dsif_pkg::seg_ident_type id_in;
   logic                    valid_ff;
   logic                    valid_in;
   logic                    match_ff;
   logic                    match_in;

   // Take the neighbor's entry on insert; the last cell's entry falls out.
   always_comb begin
      id_in    = ctrl.shift ? prev_id : id_ff;
      valid_in = ctrl.shift ? prev_valid : valid_ff;
      match_in = valid_ff && (id_ff == ctrl.query);
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   assign id_out    = id_ff;
   assign valid_out = valid_ff;
   assign match_out = match_ff;

endmodule

`default_nettype wire

// File: rtl/duplicate_segment_id_filter_core.sv
// Duplicate segment identifier filter: checks each identifier against a window of the
// WINDOW_DEPTH most recent distinct identifiers, held in a chain of cells, and reports
// hits. Each transaction passes through accept, compare in every cell in parallel
// with the match registered in the cell, then a decision that ORs the match bits and,
// on a miss, shifts the chain by one so the new identifier enters the first cell and
// the oldest leaves the last. The insert must land before the next compare, so a new
// identifier is accepted only after the decision on the last. The result sits in an output
// register, so the next identifier is accepted while a result waits. The window is
// empty after reset; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module duplicate_segment_id_filter_core #(
   parameter int WINDOW_DEPTH = dsif_pkg::WINDOW_DEPTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [dsif_pkg::ID_WIDTH-1:0]       req_tdata,  // [31:0] seg_ident
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [dsif_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata   // [0] is_duplicate, [7:1] zero
);

`include "duplicate_segment_id_filter_core_macros.svh"

   dsif_pkg::state_type     state_ff;
   dsif_pkg::state_type     state_in;
   dsif_pkg::seg_ident_type query_ff;
   dsif_pkg::seg_ident_type query_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_dup_ff;
   logic                    rsp_dup_in;

   dsif_pkg::cell_ctrl_type cell_ctrl;
   dsif_pkg::seg_ident_type cell_id [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] cell_valid;
   logic [WINDOW_DEPTH-1:0] cell_match;

   logic req_accept;
   logic out_free;
   logic any_hit;
   logic decide_go;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign any_hit    = |cell_match;
   assign decide_go  = (state_ff == dsif_pkg::ST_DECIDE) && out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dsif_pkg::ST_IDLE: begin
            if (req_accept) state_in = dsif_pkg::ST_COMPARE;
         end
         dsif_pkg::ST_COMPARE: begin
            state_in = dsif_pkg::ST_DECIDE;
         end
         dsif_pkg::ST_DECIDE: begin
            if (out_free) state_in = dsif_pkg::ST_IDLE;
         end
         default: begin
            state_in = dsif_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_tready      = 1'b0;
      cell_ctrl.shift = 1'b0;
      cell_ctrl.query = query_ff;
      case (state_ff)
         dsif_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         dsif_pkg::ST_DECIDE: begin
            cell_ctrl.shift = out_free && !any_hit;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      query_in     = req_accept ? req_tdata : query_ff;
      rsp_dup_in   = decide_go ? any_hit : rsp_dup_ff;
      rsp_valid_in = decide_go || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      query_ff   <= query_in;
      rsp_dup_ff <= rsp_dup_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsif_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Cell chain: cell 0 takes the new identifier, each later cell its neighbor's entry.
   genvar g;
   generate
      for (g = 0; g < WINDOW_DEPTH; g++) begin : gen_cell
         if (g == 0) begin : gen_head
            dsif_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctrl       (cell_ctrl),
               .prev_id    (query_ff),
               .prev_valid (1'b1),
               .id_out     (cell_id[g]),
               .valid_out  (cell_valid[g]),
               .match_out  (cell_match[g])
            );
         end else begin : gen_body
            dsif_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctrl       (cell_ctrl),
               .prev_id    (cell_id[g-1]),
               .prev_valid (cell_valid[g-1]),
               .id_out     (cell_id[g]),
               .valid_out  (cell_valid[g]),
               .match_out  (cell_match[g])
            );
         end
      end
   endgenerate

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dsif_pkg::RSP_DATA_WIDTH-1){1'b0}}, rsp_dup_ff};

   `DSIF_ASSERT_NEXT(a_accept_to_compare, clock, reset, req_accept, state_ff == dsif_pkg::ST_COMPARE, "accepted transaction did not start a compare")
   `DSIF_ASSERT_SAME(a_shift_only_on_miss, clock, reset, cell_ctrl.shift, !any_hit, "window shifted on a duplicate")
   `DSIF_ASSERT_NEXT(a_insert_fills_head, clock, reset, cell_ctrl.shift, cell_valid[0] && (cell_id[0] == $past(query_ff)), "inserted identifier missing from first cell")
   `DSIF_ASSERT_NEXT(a_decide_loads_rsp, clock, reset, decide_go, rsp_valid_ff && (rsp_dup_ff == $past(any_hit)), "decision did not load the result register")

endmodule

`default_nettype wire
